/* src/quaternion_to_euler_angles_assert.svh */
// Assertion macros for the quaternion to Euler angles block
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/qte_pkg.sv */
// Types and constants shared by the quaternion to Euler angles block
`timescale 1ns / 1ps
package qte_pkg;
  localparam int AW = 35;
  localparam int SW = 30;
  localparam int VW = 57;
  localparam int RW = 58;
  localparam int CW = 37;
  localparam int ZW = 29;
  localparam int SQ_STEPS = 29;
  localparam int MAX_STAGES = 24;

  localparam logic signed [AW-1:0] ONE_Q28 = AW'(64'sd268435456);
  localparam logic signed [ZW-1:0] PI_Q24 = ZW'(64'sd52707178);

  localparam logic [ZW-1:0] ATAN_Q24 [MAX_STAGES] = '{
    29'd13176795, 29'd7778716, 29'd4110060, 29'd2086331, 29'd1047214, 29'd524117,
    29'd262123, 29'd131069, 29'd65536, 29'd32768, 29'd16384, 29'd8192, 29'd4096,
    29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128, 29'd64, 29'd32, 29'd16, 29'd8,
    29'd4, 29'd2
  };

  typedef struct packed {
    logic [VW-1:0]          rem;
    logic [RW-1:0]          root;
    logic signed [AW-1:0]   rn;
    logic signed [AW-1:0]   rd;
    logic signed [AW-1:0]   yn;
    logic signed [AW-1:0]   yd;
    logic signed [SW-1:0]   s_val;
  } sq_t;

  typedef struct packed {
    logic                   zero;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   ang;
  } vec_t;

  typedef vec_t [2:0] lanes_t;
endpackage

/* src/qte_prep.sv */
// Products, angle operands and pitch remainder ahead of the square-root chain
`timescale 1ns / 1ps
module qte_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                vld_o,
  output qte_pkg::sq_t        data_o
);
  import qte_pkg::*;

  localparam logic signed [2*SW-1:0] TWO56 = (2*SW)'(64'sd1) <<< 56;

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, wy_q, zx_q, zz_q;
  logic signed [AW-1:0] rn_q, rd_q, yn_q, yd_q, rn_d, rd_d, yn_d, yd_d, sr_d;
  logic signed [SW-1:0] s_q, s_d;
  logic signed [2*SW-1:0] sq_d;
  logic v1_q, v2_q, v3_q;
  sq_t out_q;

  always_comb begin
    rn_d = (AW'(wx_q) + AW'(yz_q)) <<< 1;
    rd_d = ONE_Q28 - ((AW'(xx_q) + AW'(yy_q)) <<< 1);
    yn_d = (AW'(wz_q) + AW'(xy_q)) <<< 1;
    yd_d = ONE_Q28 - ((AW'(yy_q) + AW'(zz_q)) <<< 1);
    sr_d = (AW'(wy_q) - AW'(zx_q)) <<< 1;
    if (sr_d > ONE_Q28) begin
      s_d = SW'(ONE_Q28);
    end else if (sr_d < -ONE_Q28) begin
      s_d = SW'(-ONE_Q28);
    end else begin
      s_d = SW'(sr_d);
    end
    sq_d = s_q * s_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      zz_q <= quat_z_i * quat_z_i;
      rn_q <= rn_d;
      rd_q <= rd_d;
      yn_q <= yn_d;
      yd_q <= yd_d;
      s_q  <= s_d;
      out_q.rem   <= VW'(TWO56 - sq_d);
      out_q.root  <= '0;
      out_q.rn    <= rn_q;
      out_q.rd    <= rd_q;
      out_q.yn    <= yn_q;
      out_q.yd    <= yd_q;
      out_q.s_val <= s_q;
    end
  end

  assign vld_o  = v3_q;
  assign data_o = out_q;
endmodule

/* src/qte_sqrt_cell.sv */
// One digit of the pitch cosine square root
`timescale 1ns / 1ps
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  qte_pkg::sq_t  data_i,
  output logic          vld_o,
  output qte_pkg::sq_t  data_o
);
  import qte_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

  logic [RW-1:0] trial;
  sq_t           data_d, data_q;
  logic          vld_q;

  always_comb begin
    data_d = data_i;
    trial  = data_i.root + BIT;
    if (RW'(data_i.rem) >= trial) begin
      data_d.rem  = VW'(RW'(data_i.rem) - trial);
      data_d.root = (data_i.root >> 1) + BIT;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;
endmodule

/* src/qte_cordic_cell.sv */
// One vectoring rotation for the three angle lanes
`timescale 1ns / 1ps
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  qte_pkg::lanes_t data_i,
  output logic            vld_o,
  output qte_pkg::lanes_t data_o
);
  import qte_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ATAN_Q24[STAGE];

  lanes_t data_d, data_q;
  logic   vld_q;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      if (data_i[l].y < 0) begin
        data_d[l].x   = data_i[l].x - (data_i[l].y >>> STAGE);
        data_d[l].y   = data_i[l].y + (data_i[l].x >>> STAGE);
        data_d[l].ang = data_i[l].ang - ANG;
      end else begin
        data_d[l].x   = data_i[l].x + (data_i[l].y >>> STAGE);
        data_d[l].y   = data_i[l].y - (data_i[l].x >>> STAGE);
        data_d[l].ang = data_i[l].ang + ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;
endmodule

/* src/quaternion_to_euler_angles.sv */
// Top level: quaternion to roll, pitch and yaw through a chain of cells
//   channel | signals                              | transfer when
//   in      | in_valid_i, in_stall_o, quat_*_i      | in_valid_i & !in_stall_o
//   out     | out_valid_o, out_stall_i, *_angle_o   | out_valid_o & !out_stall_i
// One quaternion a cycle while no result is stalled; the chain holds three
// product/sum stages, 29 square-root cells, one quadrant stage, CORDIC_STAGES
// rotation cells (capped at 24) and the output register.
// Reset clears the valid bits only. A stalled result holds the whole chain.
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);
  import qte_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam logic signed [ZW-1:0] ROLL_LIM  = ZW'(25736);
  localparam logic signed [ZW-1:0] PITCH_LIM = ZW'(12868);

  logic   en;
  logic   sv  [SQ_STEPS+1];
  sq_t    sd  [SQ_STEPS+1];
  logic   cv  [NSTG+1];
  lanes_t cd  [NSTG+1];
  lanes_t init_d;
  logic   out_valid_q;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;

  function automatic vec_t init_lane(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x   = -x;
      v.y   = -y;
      v.ang = (y >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      v.x   = x;
      v.y   = y;
      v.ang = '0;
    end
    return v;
  endfunction

  function automatic logic signed [ZW-1:0] to_q13(vec_t v, logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = (v.ang + ZW'(1024)) >>> 11;
    if (v.zero) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  qte_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .vld_o    (sv[0]),
    .data_o   (sd[0])
  );

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(SQ_STEPS - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sv[j]),
      .data_i (sd[j]),
      .vld_o  (sv[j+1]),
      .data_o (sd[j+1])
    );
  end

  always_comb begin
    init_d[0] = init_lane(CW'(sd[SQ_STEPS].rn), CW'(sd[SQ_STEPS].rd));
    init_d[1] = init_lane(CW'(sd[SQ_STEPS].s_val), CW'(sd[SQ_STEPS].root));
    init_d[2] = init_lane(CW'(sd[SQ_STEPS].yn), CW'(sd[SQ_STEPS].yd));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0]       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      cv[0]       <= sv[SQ_STEPS];
      out_valid_q <= cv[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd[0]   <= init_d;
      roll_q  <= 16'(to_q13(cd[NSTG][0], ROLL_LIM));
      pitch_q <= 15'(to_q13(cd[NSTG][1], PITCH_LIM));
      yaw_q   <= 16'(to_q13(cd[NSTG][2], ROLL_LIM));
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    qte_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cv[i]),
      .data_i (cd[i]),
      .vld_o  (cv[i+1]),
      .data_o (cd[i+1])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;
endmodule

/* src/qte_checker.sv */
// Port-level checks for the quaternion to Euler angles block, with its bind
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_assert.svh"
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] roll_angle_o,
  input logic signed [14:0] pitch_angle_o,
  input logic signed [15:0] yaw_angle_o
);
  logic        held;
  logic [46:0] angles;
  logic        pitch_ok;
  logic        roll_ok;

  assign held     = out_valid_o && out_stall_i;
  assign angles   = {roll_angle_o, pitch_angle_o, yaw_angle_o};
  assign pitch_ok = (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868);
  assign roll_ok  = (roll_angle_o <= 16'sd25736) && (roll_angle_o >= -16'sd25736) &&
                    (yaw_angle_o <= 16'sd25736) && (yaw_angle_o >= -16'sd25736);

  `QTE_ASSERT_NXT(a_out_hold, held, out_valid_o && $stable(angles), "stalled result changed")
  `QTE_ASSERT_IMP(a_stall_cause, in_stall_o, held, "input stalled without a stalled result")
  `QTE_ASSERT_IMP(a_pitch_range, out_valid_o, pitch_ok, "pitch out of range")
  `QTE_ASSERT_IMP(a_roll_range, out_valid_o, roll_ok, "roll or yaw out of range")
endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
